### src/sint_pkg.sv
// shared constants, word types and controller states for the string interner
`default_nettype none
package sint_pkg;

  localparam int MAX_LEN     = 64;
  localparam int MAX_STRINGS = 256;
  localparam int NUM_BUCKETS = 512;
  localparam int BLOB_BYTES  = 4096;

  localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int STEP_W = $clog2(NUM_BUCKETS + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int PA_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ID_W   = $clog2(MAX_STRINGS);
  localparam int SC_W   = $clog2(MAX_STRINGS + 1);
  localparam int BA_W   = $clog2(BLOB_BYTES);
  localparam int FILL_W = $clog2(BLOB_BYTES + 1);
  localparam int ENT_W  = BA_W + LEN_W;
  localparam int STRID_W = 8;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_LONG = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] string_id;
    logic       was_new;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BRD, S_BCHK, S_ECHK, S_CMP, S_INS, S_COPY, S_CWR, S_EMIT
  } state_t;

endpackage
`default_nettype wire

### src/sint_ram.sv
// simple dual-port synchronous ram with registered read data
`default_nettype none
module sint_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/string_interner_unit.sv
// top level of the string interner: byte folding, bucket probe, compare and insert
// Byte items are taken one per cycle while idle; the hash keeps only its low
// bucket-index bits, which depend on nothing above them. A last item starts a
// linear probe: every bucket visited passes through a bucket read, an entry read
// and a check, plus one compare step per byte when the stored length matches,
// the compare streaming blob and pending bytes through their ram ports. A new
// string is copied by alternating a copy step and a write step per byte, then a
// final step writes the terminator, entry record and bucket. The emit state moves
// the result into the output register once that register is free. After reset
// the block clears its NUM_BUCKETS-entry bucket table, one entry per cycle, and
// takes no input while it clears; byte items are taken while a loaded result waits.
`default_nettype none
module string_interner_unit
  import sint_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam logic [BKT_W-1:0] PRIME_LO = HASH_PRIME[BKT_W-1:0];
  localparam logic [BKT_W-1:0] BASIS_LO = HASH_BASIS[BKT_W-1:0];
  localparam int CHK_W = FILL_W + 1;

  state_t state_r, state_nxt;
  logic [BKT_W-1:0]  hash_r, hash_nxt, hash_upd;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BKT_W-1:0]  slot_r, slot_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [BA_W-1:0]   off_r, off_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [SC_W-1:0]   stored_r, stored_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  out_word_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  logic              load;
  logic              acc;

  logic              pend_we;
  logic [PA_W-1:0]   pend_waddr, pend_raddr;
  logic [7:0]        pend_rdata;
  logic              blob_we;
  logic [BA_W-1:0]   blob_waddr, blob_raddr;
  logic [7:0]        blob_wdata, blob_rdata;
  logic              ent_we;
  logic [ID_W-1:0]   ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              bkt_we;
  logic [SC_W-1:0]   bkt_wdata, bkt_rdata;

  sint_ram #(.AW(PA_W), .DW(8)) u_pend (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(in_word.char_byte),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );
  sint_ram #(.AW(BA_W), .DW(8)) u_blob (
    .clk, .we(blob_we), .waddr(blob_waddr), .wdata(blob_wdata),
    .raddr(blob_raddr), .rdata(blob_rdata)
  );
  sint_ram #(.AW(ID_W), .DW(ENT_W)) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );
  sint_ram #(.AW(BKT_W), .DW(SC_W)) u_bkt (
    .clk, .we(bkt_we), .waddr(slot_r), .wdata(bkt_wdata),
    .raddr(slot_r), .rdata(bkt_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  // fnv-1a style step on the low bits only: xor then multiply mod 2^BKT_W; the basis is not the fnv offset basis
  assign hash_upd  = BKT_W'((hash_r ^ BKT_W'(in_word.char_byte)) * PRIME_LO);
  assign idx_inc   = idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hash_r      <= BASIS_LO;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      slot_r      <= '0;
      steps_r     <= '0;
      stored_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      slot_r      <= slot_nxt;
      steps_r     <= steps_nxt;
      stored_r    <= stored_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    off_r <= off_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (load) begin
      out_word_r <= res_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    hash_nxt   = hash_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    slot_nxt   = slot_r;
    steps_nxt  = steps_r;
    id_nxt     = id_r;
    off_nxt    = off_r;
    idx_nxt    = idx_r;
    stored_nxt = stored_r;
    fill_nxt   = fill_r;
    res_nxt    = res_r;
    load       = 1'b0;
    pend_we    = 1'b0;
    pend_waddr = cnt_r[PA_W-1:0];
    pend_raddr = idx_r[PA_W-1:0];
    blob_we    = 1'b0;
    blob_waddr = BA_W'(fill_r + FILL_W'(idx_r));
    blob_wdata = pend_rdata;
    blob_raddr = BA_W'(off_r + BA_W'(idx_r));
    ent_we     = 1'b0;
    ent_waddr  = stored_r[ID_W-1:0];
    ent_wdata  = {fill_r[BA_W-1:0], cnt_r};
    ent_raddr  = ID_W'(bkt_rdata - 1'b1);
    bkt_we     = 1'b0;
    bkt_wdata  = stored_r + 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_wdata = '0;
        slot_nxt  = slot_r + 1'b1;
        if (slot_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (in_word.has_byte) begin
            hash_nxt = hash_upd;
            if (cnt_r < LEN_W'(MAX_LEN)) begin
              pend_we = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_word.last_byte) begin
            if (ovf_r || (in_word.has_byte && cnt_r == LEN_W'(MAX_LEN))) begin
              res_nxt   = '{string_id: '0, was_new: 1'b0, status: STS_LONG};
              state_nxt = S_EMIT;
            end else begin
              slot_nxt  = in_word.has_byte ? hash_upd : hash_r;
              steps_nxt = '0;
              state_nxt = S_BRD;
            end
          end
        end
      end
      S_BRD: begin
        state_nxt = S_BCHK;
      end
      S_BCHK: begin
        if (bkt_rdata == '0) begin
          state_nxt = S_INS;
        end else begin
          id_nxt    = ent_raddr;
          state_nxt = S_ECHK;
        end
      end
      S_ECHK, S_CMP: begin
        priority if ((state_r == S_ECHK && ent_rdata[LEN_W-1:0] != cnt_r) ||
                     (state_r == S_CMP && blob_rdata != pend_rdata)) begin
          // mismatch: step to the next bucket, or report full once every bucket was probed
          slot_nxt  = slot_r + 1'b1;
          steps_nxt = steps_r + 1'b1;
          if (steps_r == STEP_W'(NUM_BUCKETS - 1)) begin
            res_nxt   = '{string_id: '0, was_new: 1'b0, status: STS_FULL};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_BRD;
          end
        end else if ((state_r == S_ECHK && cnt_r == '0) ||
                     (state_r == S_CMP && idx_inc == cnt_r)) begin
          res_nxt   = '{string_id: STRID_W'(id_r), was_new: 1'b0, status: STS_OK};
          state_nxt = S_EMIT;
        end else if (state_r == S_ECHK) begin
          off_nxt    = ent_rdata[ENT_W-1:LEN_W];
          idx_nxt    = '0;
          blob_raddr = ent_rdata[ENT_W-1:LEN_W];
          pend_raddr = '0;
          state_nxt  = S_CMP;
        end else begin
          // bytes equal so far: stream the next pair
          idx_nxt    = idx_inc;
          blob_raddr = BA_W'(off_r + BA_W'(idx_inc));
          pend_raddr = idx_inc[PA_W-1:0];
        end
      end
      S_INS: begin
        if (stored_r >= SC_W'(MAX_STRINGS) ||
            CHK_W'(fill_r) + CHK_W'(cnt_r) + 1'b1 > CHK_W'(BLOB_BYTES)) begin
          res_nxt   = '{string_id: '0, was_new: 1'b0, status: STS_FULL};
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (idx_r == cnt_r) begin
          // terminator, entry record and bucket all land this cycle
          blob_we    = 1'b1;
          blob_wdata = '0;
          ent_we     = 1'b1;
          bkt_we     = 1'b1;
          stored_nxt = stored_r + 1'b1;
          fill_nxt   = fill_r + FILL_W'(cnt_r) + 1'b1;
          res_nxt    = '{string_id: STRID_W'(stored_r), was_new: 1'b1, status: STS_OK};
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        blob_we   = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_COPY;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          hash_nxt  = BASIS_LO;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load || (out_valid_r && out_stall);
  end

`ifndef NO_ASSERTIONS
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result word appeared outside emit");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LEN_W'(MAX_LEN))
    else $error("pending count beyond max length");
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= SC_W'(MAX_STRINGS) && fill_r <= FILL_W'(BLOB_BYTES))
    else $error("store counters out of range");
  a_cmp_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_CWR) |-> idx_r < cnt_r)
    else $error("byte index ran past string length");
  a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> state_r == S_IDLE && cnt_r == '0 && !ovf_r)
    else $error("string state not cleared after result");
`endif

endmodule
`default_nettype wire

### tb/sv/sint_checker.sv
// checker for the string interner: predicts each result word and compares it
`default_nettype none
module sint_checker
  import sint_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_word_t  in_word,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_word_t out_word,
  output int             fail_count,
  output int             pending_results,
  output int             result_count,
  output int             new_count,
  output int             full_count,
  output int             long_count
);

  logic [63:0] hash_acc;
  logic [7:0]  held_bytes [MAX_LEN];
  int          held_len;
  logic        too_long;
  logic [7:0]  blob [BLOB_BYTES];
  int          str_off [MAX_STRINGS];
  int          str_len [MAX_STRINGS];
  int          buckets [NUM_BUCKETS];
  int          num_stored;
  int          fill;
  out_word_t   expected_words [$];

  initial begin
    fail_count = 0;
    pending_results = 0;
    result_count = 0;
    new_count = 0;
    full_count = 0;
    long_count = 0;
    hash_acc = HASH_BASIS;
    held_len = 0;
    too_long = 1'b0;
    num_stored = 0;
    fill = 0;
    for (int i = 0; i < NUM_BUCKETS; i++) buckets[i] = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic bit matches_held(input int id);
    if (str_len[id] != held_len) return 1'b0;
    for (int i = 0; i < held_len; i++)
      if (blob[str_off[id] + i] != held_bytes[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_word_t lookup_or_insert();
    out_word_t r;
    int slot;
    int id;
    bit empty_seen;
    r = '0;
    slot = int'(hash_acc[BKT_W-1:0]);
    empty_seen = 1'b0;
    for (int s = 0; s < NUM_BUCKETS; s++) begin
      if (buckets[slot] == 0) begin
        empty_seen = 1'b1;
        break;
      end
      if (buckets[slot] - 1 < MAX_STRINGS && matches_held(buckets[slot] - 1)) begin
        r.string_id = 8'(buckets[slot] - 1);
        r.status = STS_OK;
        return r;
      end
      slot = (slot + 1) % NUM_BUCKETS;
    end
    if (!empty_seen || num_stored >= MAX_STRINGS || fill + held_len + 1 > BLOB_BYTES) begin
      r.status = STS_FULL;
      return r;
    end
    id = num_stored;
    for (int i = 0; i < held_len; i++) blob[fill + i] = held_bytes[i];
    blob[fill + held_len] = 8'd0;
    str_off[id] = fill;
    str_len[id] = held_len;
    fill += held_len + 1;
    num_stored++;
    buckets[slot] = id + 1;
    r.string_id = 8'(id);
    r.was_new = 1'b1;
    r.status = STS_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (in_word.has_byte) begin
        hash_acc = (hash_acc ^ {56'd0, in_word.char_byte}) * HASH_PRIME;
        if (held_len < MAX_LEN) begin
          held_bytes[held_len] = in_word.char_byte;
          held_len++;
        end else begin
          too_long = 1'b1;
        end
      end
      if (in_word.last_byte) begin
        if (too_long) begin
          want = '0;
          want.status = STS_LONG;
        end else begin
          want = lookup_or_insert();
        end
        expected_words.push_back(want);
        hash_acc = HASH_BASIS;
        held_len = 0;
        too_long = 1'b0;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, status", out_word.status, -1);
      end else begin
        want = expected_words.pop_front();
        result_count++;
        if (want.was_new) new_count++;
        if (want.status == STS_FULL) full_count++;
        if (want.status == STS_LONG) long_count++;
        if (out_word.string_id !== want.string_id)
          report_mismatch("string_id", out_word.string_id, want.string_id);
        if (out_word.was_new !== want.was_new)
          report_mismatch("was_new", out_word.was_new, want.was_new);
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
      end
    end
    pending_results = expected_words.size();
  end

endmodule
`default_nettype wire

### tb/sv/tb_string_interner_unit.sv
// testbench top for the string interner: stimulus, receiver stalls and verdict
`default_nettype none
module tb_string_interner_unit;
  import sint_pkg::*;

  localparam int CYCLE_LIMIT = 900000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  int        fail_count;
  int        pending_results;
  int        result_count;
  int        new_count;
  int        full_count;
  int        long_count;
  int        cycle_count;
  int        items_sent;
  bit        hold_off;
  bit        hold_done;
  logic [7:0] pool [8][$];

  string_interner_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  sint_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .pending_results(pending_results),
    .result_count(result_count), .new_count(new_count),
    .full_count(full_count), .long_count(long_count)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    items_sent = 0;
    hold_off = 1'b0;
    hold_done = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: own stall pattern, plus long hold-off when asked
  initial begin
    int mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        if (hold_off) out_stall <= 1'b1;
        else if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
        else out_stall <= ($urandom_range(0, 5) != 0);
      end
    end
  end

  // send one word; valid stays high if another word follows without a gap
  task automatic send_word(input logic [7:0] b, input logic has, input logic last);
    in_word_t w;
    w.char_byte = b;
    w.has_byte = has;
    w.last_byte = last;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_string(input logic [7:0] s [$], input bit ignored_noise);
    for (int i = 0; i < s.size(); i++) begin
      if (ignored_noise && $urandom_range(0, 7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(s[i], 1'b1, i == s.size() - 1);
    end
    if (s.size() == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic void make_random(output logic [7:0] s [$], input int len);
    s = {};
    for (int i = 0; i < len; i++) s.push_back(8'($urandom));
  endfunction

  initial begin
    logic [7:0] s [$];
    int len;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty string twice, extremes of byte values, lengths around the limit
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h5a, 1'b0, 1'b1);
    s = {8'h00}; send_string(s, 0);
    s = {8'hff}; send_string(s, 0);
    s = {8'h00}; send_string(s, 0);
    s = {8'hff, 8'h00}; send_string(s, 0);
    s = {8'haa, 8'h55, 8'hff}; send_string(s, 0);
    s = {8'hff}; send_string(s, 0);
    s = {}; for (int i = 0; i < MAX_LEN; i++) s.push_back(8'(i * 37));
    send_string(s, 0);
    s.push_back(8'h11); send_string(s, 0);
    // byte then a no-byte last item
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    // random: pool strings and fresh strings alike often, plus too-long strings and noise
    for (int p = 0; p < 8; p++) begin
      make_random(s, $urandom_range(0, 6));
      pool[p] = s;
    end
    while (items_sent < 1000) begin
      if (items_sent > 500 && !hold_done) begin
        hold_done = 1'b1;
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      k = $urandom_range(0, 9);
      if (k < 4) begin
        send_string(pool[$urandom_range(0, 7)], 1);
      end else if (k < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN + 3)
                                         : $urandom_range(0, 5);
        make_random(s, len);
        send_string(s, 1);
      end else if (k == 8) begin
        make_random(s, $urandom_range(MAX_LEN + 1, MAX_LEN + 4));
        send_string(s, 0);
      end else begin
        send_word(8'($urandom), 1'b0, 1'b0);
      end
    end
    // fill the id space so the full status shows up
    while (full_count < 4 && cycle_count < CYCLE_LIMIT / 2) begin
      make_random(s, 3);
      send_string(s, 0);
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d words, %0d results: %0d new, %0d full, %0d too long",
             items_sent, result_count, new_count, full_count, long_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
